// ----- hdl/sek_pkg.sv -----
// Shared types, constants and the exponent table of the SE kernel block.
`default_nettype none
package sek_pkg;

   localparam int MAX_DIM_DEF   = 6;
   localparam int MAX_DERIV_DEF = 7;
   localparam int NUM_LEN       = 6;

   localparam int COORD_W    = 24;
   localparam int DIFF_W     = 25;
   localparam int GAIN_W     = 24;
   localparam int IDX_W      = 3;
   localparam int CNT_W      = 3;
   localparam int COV_W      = 32;
   localparam int LEN_IW     = 3;

   localparam int MUL_AW     = 52;
   localparam int MUL_BW     = 40;
   localparam int MUL_PW     = 92;
   localparam int MUL_DIG    = 8;
   localparam int MUL_STEPS  = 5;
   localparam int STEP_W     = 3;

   localparam int NORM_W     = 59;
   localparam int K_W        = 40;
   localparam int E_W        = 33;
   localparam int BORD_W     = 33;
   localparam int PM_W       = 52;
   localparam int EXP_BITS   = 21;
   localparam int BIT_W      = 5;

   localparam int REQ_DATA_W = 56;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 40;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   localparam logic [CSR_IDX_W-1:0] REG_ALPHA = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DIMS  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LEN0  = 3'd2;

   localparam logic [GAIN_W-1:0] ONE_Q16 = 24'd65536;

   typedef enum logic [1:0] {
      FN_PAIR    = 2'd0,
      FN_LIST1   = 2'd1,
      FN_LIST2   = 2'd2,
      FN_COMPUTE = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      MS_SQ    = 3'd0,
      MS_NW    = 3'd1,
      MS_EXP   = 3'd2,
      MS_ALPHA = 3'd3,
      MS_BORD  = 3'd4,
      MS_INNER = 3'd5,
      MS_SCALE = 3'd6
   } mul_sel_type;

   typedef struct packed {
      logic              load;
      logic              norm_clr;
      logic              e_init;
      logic              k_zero;
      logic              mul_start;
      mul_sel_type       mul_sel;
      logic              side_col;
      logic              v_kern;
      logic              emit;
      logic              last;
      logic              clear_lists;
      logic [IDX_W-1:0]  k;
      logic [BIT_W-1:0]  bitj;
      logic [CNT_W-1:0]  ri;
      logic [CNT_W-1:0]  cj;
   } sek_cmd_type;

   typedef struct packed {
      logic              mul_done;
      logic              x_big;
      logic              x_bit;
      logic [IDX_W-1:0]  dims_eff;
      logic [CNT_W-1:0]  cnt1;
      logic [CNT_W-1:0]  cnt2;
      logic              out_free;
   } sek_stat_type;

   // exp(-2^(j-16)) in unsigned Q0.32
   function automatic logic [31:0] exp_tab(input logic [BIT_W-1:0] j);
      logic [31:0] r;
      case (j)
         5'd0:  r = 32'd4294901760;
         5'd1:  r = 32'd4294836226;
         5'd2:  r = 32'd4294705160;
         5'd3:  r = 32'd4294443040;
         5'd4:  r = 32'd4293918848;
         5'd5:  r = 32'd4292870656;
         5'd6:  r = 32'd4290775039;
         5'd7:  r = 32'd4286586875;
         5'd8:  r = 32'd4278222805;
         5'd9:  r = 32'd4261543595;
         5'd10: r = 32'd4228380000;
         5'd11: r = 32'd4162825044;
         5'd12: r = 32'd4034748382;
         5'd13: r = 32'd3790295335;
         5'd14: r = 32'd3344923893;
         5'd15: r = 32'd2605029347;
         5'd16: r = 32'd1580030169;
         5'd17: r = 32'd581260615;
         5'd18: r = 32'd78665070;
         5'd19: r = 32'd1440801;
         5'd20: r = 32'd483;
         default: r = 32'd0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

// ----- hdl/sek_mul.sv -----
// Shared multi-cycle multiplier, one 8-bit digit of the second operand per cycle.
`default_nettype none
module sek_mul
   import sek_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [MUL_AW-1:0] op_a,
   input  wire logic [MUL_BW-1:0] op_b,
   output logic                   done,
   output logic [MUL_PW-1:0]      prod
);

   logic [MUL_PW-1:0] a_sh_ff, a_sh_in, acc_ff, acc_in, part;
   logic [MUL_BW-1:0] b_sh_ff, b_sh_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in, done_ff, done_in;

   assign part = a_sh_ff * MUL_PW'(b_sh_ff[MUL_DIG-1:0]);

   always_comb begin
      a_sh_in = a_sh_ff;
      b_sh_in = b_sh_ff;
      acc_in  = acc_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_sh_in = MUL_PW'(op_a);
         b_sh_in = op_b;
         acc_in  = '0;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in  = acc_ff + part;
         a_sh_in = a_sh_ff << MUL_DIG;
         b_sh_in = b_sh_ff >> MUL_DIG;
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(MUL_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_sh_ff <= a_sh_in;
      b_sh_ff <= b_sh_in;
      acc_ff  <= acc_in;
      if (reset) begin
         step_ff <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign prod = acc_ff;

endmodule
`default_nettype wire

// ----- hdl/sek_dp.sv -----
// Datapath: stores, config registers, kernel arithmetic and the result register.
`default_nettype none
module sek_dp
   import sek_pkg::*;
#(
   parameter int MAX_DIM   = MAX_DIM_DEF,
   parameter int MAX_DERIV = MAX_DERIV_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire sek_cmd_type           cmd,
   output sek_stat_type               stat,
   input  wire func_type              req_func,
   input  wire logic [IDX_W-1:0]      req_dim,
   input  wire logic [COORD_W-1:0]    req_coord_one,
   input  wire logic [COORD_W-1:0]    req_coord_two,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                  rsp_tready,
   output logic                       rsp_valid,
   output logic [CNT_W-1:0]           rsp_row,
   output logic [CNT_W-1:0]           rsp_col,
   output logic [COV_W-1:0]           rsp_cov,
   output logic                       rsp_last
);

   localparam int DIM_IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int LST_IW = (MAX_DERIV > 1) ? $clog2(MAX_DERIV) : 1;

   logic [GAIN_W-1:0]        alpha_ff;
   logic [IDX_W-1:0]         dims_ff;
   logic [GAIN_W-1:0]        w_ff [NUM_LEN];
   logic signed [COORD_W-1:0] p1_ff [MAX_DIM];
   logic signed [COORD_W-1:0] p2_ff [MAX_DIM];
   logic [IDX_W-1:0]         l1_ff [MAX_DERIV];
   logic [IDX_W-1:0]         l2_ff [MAX_DERIV];
   logic [CNT_W-1:0]         cnt1_ff, cnt2_ff;

   logic [NORM_W-1:0]        norm_ff;
   logic [E_W-1:0]           e_ff;
   logic [K_W-1:0]           k_ff;
   logic [BORD_W-1:0]        br_ff, bc_ff;
   logic                     brn_ff, bcn_ff;
   logic [PM_W-1:0]          pmag_ff;
   logic                     pneg_ff;
   logic [COV_W-1:0]         v_ff;
   mul_sel_type              sel_ff;
   logic                     side_ff, bneg_ff, sneg_ff;
   logic [GAIN_W-1:0]        wc_ff;

   logic                     rv_ff;
   logic [CNT_W-1:0]         rrow_ff, rcol_ff;
   logic [COV_W-1:0]         rcov_ff;
   logic                     rlast_ff;

   logic [CNT_W-1:0]         ri_m1, cj_m1;
   logic [IDX_W-1:0]         lr, lc, sel_dim;
   logic signed [DIFF_W-1:0] d12;
   logic [DIFF_W-1:0]        mag_d;
   logic                     bord_neg;
   logic [GAIN_W-1:0]        w_sel;
   logic [MUL_AW-1:0]        op_a;
   logic [MUL_BW-1:0]        op_b;
   logic                     mul_done;
   logic [MUL_PW-1:0]        prod;
   logic                     scale_neg;
   logic [MUL_AW-1:0]        scale_a;
   logic [65:0]              exp_r;
   logic [BORD_W-1:0]        bmag;
   logic [PM_W-1:0]          pm, ps, pv;
   logic [60:0]              m_sc;
   logic [COV_W-1:0]         v_sc;
   logic [EXP_BITS-1:0]      xv;

   assign ri_m1 = cmd.ri - CNT_W'(1);
   assign cj_m1 = cmd.cj - CNT_W'(1);
   assign lr    = l1_ff[ri_m1[LST_IW-1:0]];
   assign lc    = l2_ff[cj_m1[LST_IW-1:0]];

   always_comb begin
      if (cmd.mul_sel == MS_BORD) begin
         sel_dim = cmd.side_col ? lc : lr;
      end else begin
         sel_dim = cmd.k;
      end
   end

   assign d12      = DIFF_W'(p1_ff[sel_dim[DIM_IW-1:0]]) - DIFF_W'(p2_ff[sel_dim[DIM_IW-1:0]]);
   assign mag_d    = d12[DIFF_W-1] ? DIFF_W'(-d12) : DIFF_W'(d12);
   // row border uses p2-p1, column border p1-p2
   assign bord_neg = cmd.side_col ? d12[DIFF_W-1] : (d12 > 0);
   assign w_sel    = w_ff[sel_dim[LEN_IW-1:0]];

   always_comb begin
      if (cmd.ri != '0 && cmd.cj != '0) begin
         scale_a   = pmag_ff;
         scale_neg = pneg_ff;
      end else if (cmd.ri != '0) begin
         scale_a   = MUL_AW'(br_ff);
         scale_neg = brn_ff;
      end else begin
         scale_a   = MUL_AW'(bc_ff);
         scale_neg = bcn_ff;
      end
   end

   always_comb begin
      op_a = MUL_AW'(mag_d);
      op_b = MUL_BW'(mag_d);
      case (cmd.mul_sel)
         MS_SQ: begin
            op_a = MUL_AW'(mag_d);
            op_b = MUL_BW'(mag_d);
         end
         MS_NW: begin
            op_a = MUL_AW'(prod[47:16]);
            op_b = MUL_BW'(w_sel);
         end
         MS_EXP: begin
            op_a = MUL_AW'(e_ff);
            op_b = MUL_BW'(exp_tab(cmd.bitj));
         end
         MS_ALPHA: begin
            op_a = MUL_AW'(alpha_ff);
            op_b = MUL_BW'(e_ff);
         end
         MS_BORD: begin
            op_a = MUL_AW'(mag_d);
            op_b = MUL_BW'(w_sel);
         end
         MS_INNER: begin
            op_a = MUL_AW'(br_ff);
            op_b = MUL_BW'(bc_ff);
         end
         MS_SCALE: begin
            op_a = scale_a;
            op_b = k_ff;
         end
         default: ;
      endcase
   end

   sek_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (cmd.mul_start),
      .op_a  (op_a),
      .op_b  (op_b),
      .done  (mul_done),
      .prod  (prod)
   );

   // rounding and saturation of the finished product
   assign exp_r = prod[65:0] + 66'h0_8000_0000;
   assign bmag  = BORD_W'(prod[47:16]) + BORD_W'(prod[15]);
   assign pm    = PM_W'(prod[65:16]) + PM_W'(prod[15]);
   assign ps    = (brn_ff ^ bcn_ff) ? -pm : pm;
   assign pv    = ps + ((lr == lc) ? PM_W'(wc_ff) : '0);
   assign m_sc  = 61'(prod[91:32]) + 61'(prod[31]);

   always_comb begin
      if (sneg_ff) begin
         v_sc = (m_sc > 61'h8000_0000) ? 32'h8000_0000 : -m_sc[COV_W-1:0];
      end else begin
         v_sc = (m_sc > 61'h7FFF_FFFF) ? 32'h7FFF_FFFF : m_sc[COV_W-1:0];
      end
   end

   // config and point stores
   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= ONE_Q16;
         dims_ff  <= IDX_W'(1);
         for (int n = 0; n < NUM_LEN; n++) w_ff[n] <= ONE_Q16;
         for (int n = 0; n < MAX_DIM; n++) begin
            p1_ff[n] <= '0;
            p2_ff[n] <= '0;
         end
         cnt1_ff <= '0;
         cnt2_ff <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_ALPHA: alpha_ff <= csr_wdata;
               REG_DIMS:  dims_ff  <= csr_wdata[IDX_W-1:0];
               default: begin
                  if (csr_index >= REG_LEN0) begin
                     w_ff[LEN_IW'(csr_index - REG_LEN0)] <= csr_wdata;
                  end
               end
            endcase
         end
         if (cmd.load && req_dim < IDX_W'(MAX_DIM)) begin
            case (req_func)
               FN_PAIR: begin
                  p1_ff[req_dim[DIM_IW-1:0]] <= req_coord_one;
                  p2_ff[req_dim[DIM_IW-1:0]] <= req_coord_two;
               end
               FN_LIST1: begin
                  if (cnt1_ff < CNT_W'(MAX_DERIV)) cnt1_ff <= cnt1_ff + CNT_W'(1);
               end
               FN_LIST2: begin
                  if (cnt2_ff < CNT_W'(MAX_DERIV)) cnt2_ff <= cnt2_ff + CNT_W'(1);
               end
               default: ;
            endcase
         end
         if (cmd.clear_lists) begin
            cnt1_ff <= '0;
            cnt2_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load && req_dim < IDX_W'(MAX_DIM)) begin
         if (req_func == FN_LIST1 && cnt1_ff < CNT_W'(MAX_DERIV)) begin
            l1_ff[cnt1_ff[LST_IW-1:0]] <= req_dim;
         end
         if (req_func == FN_LIST2 && cnt2_ff < CNT_W'(MAX_DERIV)) begin
            l2_ff[cnt2_ff[LST_IW-1:0]] <= req_dim;
         end
      end
   end

   // arithmetic registers
   always_ff @(posedge clock) begin
      if (cmd.norm_clr) norm_ff <= '0;
      if (cmd.e_init)   e_ff    <= E_W'(1) << 32;
      if (cmd.k_zero)   k_ff    <= '0;
      if (cmd.v_kern)   v_ff    <= COV_W'(k_ff[K_W-1:16]) + COV_W'(k_ff[15]);
      if (mul_done) begin
         case (sel_ff)
            MS_NW:    norm_ff <= norm_ff + NORM_W'(prod[55:0]);
            MS_EXP:   e_ff    <= exp_r[64:32];
            MS_ALPHA: k_ff    <= K_W'(prod[55:16]) + K_W'(prod[15]);
            MS_BORD: begin
               if (side_ff) begin
                  bc_ff  <= bmag;
                  bcn_ff <= bneg_ff;
               end else begin
                  br_ff  <= bmag;
                  brn_ff <= bneg_ff;
               end
            end
            MS_INNER: begin
               pneg_ff <= pv[PM_W-1];
               pmag_ff <= pv[PM_W-1] ? -pv : pv;
            end
            MS_SCALE: v_ff <= v_sc;
            default: ;
         endcase
      end
      if (cmd.mul_start) begin
         side_ff <= cmd.side_col;
         bneg_ff <= bord_neg;
         sneg_ff <= scale_neg;
         if (cmd.mul_sel == MS_BORD && cmd.side_col) wc_ff <= w_sel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff <= MS_SQ;
         rv_ff  <= 1'b0;
      end else begin
         if (cmd.mul_start) sel_ff <= cmd.mul_sel;
         if (cmd.emit) begin
            rv_ff <= 1'b1;
         end else if (rsp_tready) begin
            rv_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rrow_ff  <= cmd.ri;
         rcol_ff  <= cmd.cj;
         rcov_ff  <= v_ff;
         rlast_ff <= cmd.last;
      end
   end

   assign xv = norm_ff[17 +: EXP_BITS];

   always_comb begin
      stat.mul_done = mul_done;
      stat.x_big    = |norm_ff[NORM_W-1:17+EXP_BITS];
      stat.x_bit    = xv[cmd.bitj];
      stat.dims_eff = (dims_ff > IDX_W'(MAX_DIM)) ? IDX_W'(MAX_DIM) : dims_ff;
      stat.cnt1     = cnt1_ff;
      stat.cnt2     = cnt2_ff;
      stat.out_free = !rv_ff || rsp_tready;
   end

   assign rsp_valid = rv_ff;
   assign rsp_row   = rrow_ff;
   assign rsp_col   = rcol_ff;
   assign rsp_cov   = rcov_ff;
   assign rsp_last  = rlast_ff;

endmodule
`default_nettype wire

// ----- hdl/sek_ctrl.sv -----
// Controller: sequences norm, exponent, borders and block entries.
`default_nettype none
module sek_ctrl
   import sek_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   input  wire func_type     req_func,
   output logic              req_tready,
   input  wire sek_stat_type stat,
   output sek_cmd_type       cmd
);

   typedef enum logic [15:0] {
      ST_IDLE    = 16'h0001,
      ST_NORM    = 16'h0002,
      ST_W_SQ    = 16'h0004,
      ST_W_NW    = 16'h0008,
      ST_EXPI    = 16'h0010,
      ST_EXPB    = 16'h0020,
      ST_W_EXP   = 16'h0040,
      ST_W_ALPHA = 16'h0080,
      ST_ENT     = 16'h0100,
      ST_W_BR    = 16'h0200,
      ST_W_BC    = 16'h0400,
      ST_VAL     = 16'h0800,
      ST_W_IN    = 16'h1000,
      ST_SCS     = 16'h2000,
      ST_W_SC    = 16'h4000,
      ST_EMIT    = 16'h8000
   } state_type;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] k_ff, k_in;
   logic [BIT_W-1:0] bit_ff, bit_in;
   logic [CNT_W-1:0] ri_ff, ri_in, cj_ff, cj_in;

   always_comb begin
      state_in   = state_ff;
      k_in       = k_ff;
      bit_in     = bit_ff;
      ri_in      = ri_ff;
      cj_in      = cj_ff;
      cmd        = '0;
      cmd.k      = k_ff;
      cmd.bitj   = bit_ff;
      cmd.ri     = ri_ff;
      cmd.cj     = cj_ff;
      req_tready = (state_ff == ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_func == FN_COMPUTE) begin
                  cmd.norm_clr = 1'b1;
                  k_in         = '0;
                  state_in     = ST_NORM;
               end else begin
                  cmd.load = 1'b1;
               end
            end
         end
         ST_NORM: begin
            if (k_ff < stat.dims_eff) begin
               cmd.mul_start = 1'b1;
               cmd.mul_sel   = MS_SQ;
               state_in      = ST_W_SQ;
            end else begin
               cmd.e_init = 1'b1;
               state_in   = ST_EXPI;
            end
         end
         ST_W_SQ: begin
            if (stat.mul_done) begin
               cmd.mul_start = 1'b1;
               cmd.mul_sel   = MS_NW;
               state_in      = ST_W_NW;
            end
         end
         ST_W_NW: begin
            if (stat.mul_done) begin
               k_in     = k_ff + IDX_W'(1);
               state_in = ST_NORM;
            end
         end
         ST_EXPI: begin
            ri_in = '0;
            cj_in = '0;
            if (stat.x_big) begin
               cmd.k_zero = 1'b1;
               state_in   = ST_ENT;
            end else begin
               bit_in   = '0;
               state_in = ST_EXPB;
            end
         end
         ST_EXPB: begin
            if (bit_ff == BIT_W'(EXP_BITS)) begin
               cmd.mul_start = 1'b1;
               cmd.mul_sel   = MS_ALPHA;
               state_in      = ST_W_ALPHA;
            end else if (stat.x_bit) begin
               cmd.mul_start = 1'b1;
               cmd.mul_sel   = MS_EXP;
               state_in      = ST_W_EXP;
            end else begin
               bit_in = bit_ff + BIT_W'(1);
            end
         end
         ST_W_EXP: begin
            if (stat.mul_done) begin
               bit_in   = bit_ff + BIT_W'(1);
               state_in = ST_EXPB;
            end
         end
         ST_W_ALPHA: begin
            if (stat.mul_done) state_in = ST_ENT;
         end
         ST_ENT: begin
            if (ri_ff != '0) begin
               cmd.mul_start = 1'b1;
               cmd.mul_sel   = MS_BORD;
               state_in      = ST_W_BR;
            end else if (cj_ff != '0) begin
               cmd.mul_start = 1'b1;
               cmd.mul_sel   = MS_BORD;
               cmd.side_col  = 1'b1;
               state_in      = ST_W_BC;
            end else begin
               state_in = ST_VAL;
            end
         end
         ST_W_BR: begin
            if (stat.mul_done) begin
               if (cj_ff != '0) begin
                  cmd.mul_start = 1'b1;
                  cmd.mul_sel   = MS_BORD;
                  cmd.side_col  = 1'b1;
                  state_in      = ST_W_BC;
               end else begin
                  state_in = ST_VAL;
               end
            end
         end
         ST_W_BC: begin
            if (stat.mul_done) state_in = ST_VAL;
         end
         ST_VAL: begin
            if (ri_ff == '0 && cj_ff == '0) begin
               cmd.v_kern = 1'b1;
               state_in   = ST_EMIT;
            end else if (ri_ff != '0 && cj_ff != '0) begin
               cmd.mul_start = 1'b1;
               cmd.mul_sel   = MS_INNER;
               state_in      = ST_W_IN;
            end else begin
               cmd.mul_start = 1'b1;
               cmd.mul_sel   = MS_SCALE;
               state_in      = ST_W_SC;
            end
         end
         ST_W_IN: begin
            if (stat.mul_done) state_in = ST_SCS;
         end
         ST_SCS: begin
            cmd.mul_start = 1'b1;
            cmd.mul_sel   = MS_SCALE;
            state_in      = ST_W_SC;
         end
         ST_W_SC: begin
            if (stat.mul_done) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               cmd.last = (ri_ff == stat.cnt1) && (cj_ff == stat.cnt2);
               if (ri_ff < stat.cnt1) begin
                  ri_in    = ri_ff + CNT_W'(1);
                  state_in = ST_ENT;
               end else begin
                  ri_in = '0;
                  if (cj_ff < stat.cnt2) begin
                     cj_in    = cj_ff + CNT_W'(1);
                     state_in = ST_ENT;
                  end else begin
                     cmd.clear_lists = 1'b1;
                     state_in        = ST_IDLE;
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         k_ff     <= '0;
         bit_ff   <= '0;
         ri_ff    <= '0;
         cj_ff    <= '0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
         bit_ff   <= bit_in;
         ri_ff    <= ri_in;
         cj_ff    <= cj_in;
      end
   end

endmodule
`default_nettype wire

// ----- hdl/se_kernel_with_derivative_blocks.sv -----
// A load word (pair or derivative index) is taken while idle and gives no result.
// Compute word: the norm per dimension, a scan of the exponent bits with a product
// per set bit, the gain, then each entry: (0,0), a border or an inner entry; each
// product waits on the shared 8-bit-digit multiplier, which sets the pace.
// One compute word at a time.
// Reset (synchronous, active high) restores config defaults, zeroes points and lists.
`default_nettype none
module se_kernel_with_derivative_blocks
   import sek_pkg::*;
#(
   parameter int MAX_DIM   = MAX_DIM_DEF,
   parameter int MAX_DERIV = MAX_DERIV_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request words
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,  // dim_index, coord_one, coord_two
   input  wire logic [REQ_USER_W-1:0] req_tuser,  // func
   // block entries
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,  // row_index, col_index, cov_value
   output logic                       rsp_tlast,  // last_entry
   // config writes
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   sek_cmd_type      cmd;
   sek_stat_type     stat;
   func_type         req_func;
   logic [CNT_W-1:0] rsp_row, rsp_col;
   logic [COV_W-1:0] rsp_cov;

   assign req_func = func_type'(req_tuser);

   // controller owns sequencing; datapath owns all stores and arithmetic
   sek_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_func   (req_func),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   sek_dp #(
      .MAX_DIM   (MAX_DIM),
      .MAX_DERIV (MAX_DERIV)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .req_func      (req_func),
      .req_dim       (req_tdata[2:0]),
      .req_coord_one (req_tdata[26:3]),
      .req_coord_two (req_tdata[50:27]),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .rsp_tready    (rsp_tready),
      .rsp_valid     (rsp_tvalid),
      .rsp_row       (rsp_row),
      .rsp_col       (rsp_col),
      .rsp_cov       (rsp_cov),
      .rsp_last      (rsp_tlast)
   );

   assign rsp_tdata = {2'b00, rsp_cov, rsp_col, rsp_row};

endmodule
`default_nettype wire

// ----- hdl/sek_chk.sv -----
// Port-level checker for the SE kernel block and its bind.
`default_nettype none
module sek_chk
   import sek_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tvalid,
   input wire logic                  req_tready,
   input wire logic [REQ_USER_W-1:0] req_tuser,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input wire logic                  rsp_tlast
);

   // stalled entry holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp word changed while stalled");

   // a compute word makes the block busy next cycle
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == FN_COMPUTE |=> !req_tready)
      else $error("ready after compute word");

   // kernel value entry is never negative
   a_kern_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2:0] == 3'd0 && rsp_tdata[5:3] == 3'd0 |-> !rsp_tdata[37])
      else $error("negative kernel value");

   // when idle only the last entry of a block may still be pending
   a_idle_last: assert property (@(posedge clock) disable iff (reset)
      req_tready && rsp_tvalid |-> rsp_tlast)
      else $error("idle with an unfinished block");

endmodule

bind se_kernel_with_derivative_blocks sek_chk u_sek_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
`default_nettype wire

// ----- sim/se_kernel_checker.sv -----
// Checker for the SE kernel block: watches all ports, predicts each covariance block, compares.
`timescale 1ns / 1ps
module se_kernel_checker
   import sek_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   input  wire logic                  req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic [REQ_USER_W-1:0] req_tuser,
   input  wire logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   input  wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input  wire logic                  rsp_tlast,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output int                         errors,
   output int                         pending
);

   typedef struct {
      logic [2:0]  row;
      logic [2:0]  col;
      logic [31:0] cov;
      logic        last;
   } cov_entry_t;

   // exp(-2^(j-16)) in Q0.32
   localparam logic [31:0] EXP_STEP [21] = '{
      32'd4294901760, 32'd4294836226, 32'd4294705160, 32'd4294443040,
      32'd4293918848, 32'd4292870656, 32'd4290775039, 32'd4286586875,
      32'd4278222805, 32'd4261543595, 32'd4228380000, 32'd4162825044,
      32'd4034748382, 32'd3790295335, 32'd3344923893, 32'd2605029347,
      32'd1580030169, 32'd581260615,  32'd78665070,   32'd1440801,
      32'd483};

   cov_entry_t  entry_q[$];
   logic [23:0] gain;
   logic [2:0]  dims;
   logic [23:0] inv_len [6];
   longint      pt_one [6];
   longint      pt_two [6];
   logic [2:0]  list_one [7];
   logic [2:0]  list_two [7];
   int          cnt_one, cnt_two;

   function automatic logic [127:0] round_half_up(logic [127:0] u, int s);
      return (u >> s) + ((u >> (s - 1)) & 128'd1);
   endfunction

   function automatic logic [63:0] magnitude(longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic logic [31:0] sat_round(bit neg, logic [127:0] prod, int s);
      logic [127:0] m;
      m = round_half_up(prod, s);
      if (neg)
         return (m > 128'h8000_0000) ? 32'h8000_0000 : (~m[31:0] + 32'd1);
      return (m > 128'h7fff_ffff) ? 32'h7fff_ffff : m[31:0];
   endfunction

   function automatic longint border_of(longint d, logic [23:0] w);
      logic [127:0] r;
      r = round_half_up(128'(magnitude(d)) * w, 16);
      return d < 0 ? -longint'(r[63:0]) : longint'(r[63:0]);
   endfunction

   // alpha * exp(-norm/2) in Q.32
   function automatic logic [127:0] kernel_q32();
      logic [63:0]  norm, ad, x;
      logic [127:0] e;
      int           n;
      norm = 0;
      n = (dims > 6) ? 6 : dims;
      for (int k = 0; k < n; k++) begin
         ad = magnitude(pt_one[k] - pt_two[k]);
         norm += ((ad * ad) >> 16) * inv_len[k];
      end
      x = norm >> 17;
      if ((x >> 21) != 0) return 0;
      e = 128'd1 << 32;
      for (int j = 0; j < 21; j++)
         if (x[j]) e = (e * EXP_STEP[j] + (128'd1 << 31)) >> 32;
      return round_half_up(128'(gain) * e, 16);
   endfunction

   task automatic predict_block();
      longint       brow [7];
      longint       bcol [7];
      longint       a, b, p;
      logic [127:0] kern, pm;
      cov_entry_t   ent;
      int           total, cnt, ix;
      for (int i = 0; i < cnt_one; i++) begin
         ix = list_one[i] % 6;
         brow[i] = border_of(pt_two[ix] - pt_one[ix], inv_len[ix]);
      end
      for (int j = 0; j < cnt_two; j++) begin
         ix = list_two[j] % 6;
         bcol[j] = border_of(pt_one[ix] - pt_two[ix], inv_len[ix]);
      end
      kern  = kernel_q32();
      total = (cnt_one + 1) * (cnt_two + 1);
      cnt   = 0;
      for (int j = 0; j <= cnt_two; j++) begin
         for (int i = 0; i <= cnt_one; i++) begin
            if (i == 0 && j == 0)
               ent.cov = sat_round(1'b0, kern, 16);
            else if (j == 0)
               ent.cov = sat_round(brow[i-1] < 0, magnitude(brow[i-1]) * kern, 32);
            else if (i == 0)
               ent.cov = sat_round(bcol[j-1] < 0, magnitude(bcol[j-1]) * kern, 32);
            else begin
               a  = brow[i-1];
               b  = bcol[j-1];
               pm = round_half_up(128'(magnitude(a)) * magnitude(b), 16);
               p  = ((a < 0) != (b < 0)) ? -longint'(pm[63:0]) : longint'(pm[63:0]);
               if (list_one[i-1] == list_two[j-1])
                  p += inv_len[list_two[j-1] % 6];
               ent.cov = sat_round(p < 0, 128'(magnitude(p)) * kern, 32);
            end
            ent.row  = i;
            ent.col  = j;
            ent.last = (cnt == total - 1);
            entry_q.push_back(ent);
            cnt++;
         end
      end
      cnt_one = 0;
      cnt_two = 0;
   endtask

   initial begin
      errors  = 0;
      pending = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         gain    = 24'd65536;
         dims    = 3'd1;
         cnt_one = 0;
         cnt_two = 0;
         for (int k = 0; k < 6; k++) begin
            inv_len[k] = 24'd65536;
            pt_one[k]  = 0;
            pt_two[k]  = 0;
         end
         entry_q.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == REG_ALPHA) gain = csr_wdata;
            else if (csr_index == REG_DIMS) dims = csr_wdata[2:0];
            else if (csr_index >= REG_LEN0) inv_len[csr_index - REG_LEN0] = csr_wdata;
         end
         if (req_tvalid && req_tready) begin
            case (func_type'(req_tuser))
               FN_PAIR: if (req_tdata[2:0] < 6) begin
                  pt_one[req_tdata[2:0]] = longint'(signed'(req_tdata[26:3]));
                  pt_two[req_tdata[2:0]] = longint'(signed'(req_tdata[50:27]));
               end
               FN_LIST1: if (req_tdata[2:0] < 6 && cnt_one < 7) begin
                  list_one[cnt_one] = req_tdata[2:0];
                  cnt_one++;
               end
               FN_LIST2: if (req_tdata[2:0] < 6 && cnt_two < 7) begin
                  list_two[cnt_two] = req_tdata[2:0];
                  cnt_two++;
               end
               default: predict_block();
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (entry_q.size() == 0) begin
               $error("unexpected entry row %0d col %0d", rsp_tdata[2:0], rsp_tdata[5:3]);
               errors++;
            end else begin
               cov_entry_t want;
               want = entry_q.pop_front();
               if (rsp_tdata[2:0] !== want.row) begin
                  $error("row_index: expected %0d, got %0d", want.row, rsp_tdata[2:0]);
                  errors++;
               end
               if (rsp_tdata[5:3] !== want.col) begin
                  $error("col_index: expected %0d, got %0d", want.col, rsp_tdata[5:3]);
                  errors++;
               end
               if (rsp_tdata[37:6] !== want.cov) begin
                  $error("cov_value: expected %0d, got %0d", $signed(want.cov),
                         $signed(rsp_tdata[37:6]));
                  errors++;
               end
               if (rsp_tlast !== want.last) begin
                  $error("last_entry: expected %0d, got %0d", want.last, rsp_tlast);
                  errors++;
               end
            end
         end
      end
      pending = entry_q.size();
   end

endmodule

// ----- sim/tb.sv -----
// Top of the SE kernel testbench: clock, reset, stimulus, config phases and verdict.
`timescale 1ns / 1ps
module tb;
   import sek_pkg::*;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // dim_index, coord_one, coord_two
   logic [REQ_USER_W-1:0] req_tuser;   // func
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // row_index, col_index, cov_value
   logic                  rsp_tlast;   // last_entry
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    errors;
   int                    pending;
   int                    sent;        // request words accepted so far

   bit quiet;      // no idling on either side while set
   bit hold_rsp;   // receiver takes one long break when set

   se_kernel_with_derivative_blocks DUT (.*);

   se_kernel_checker checker_i (.*);

   // 20 ns clock
   always begin
      clock = 1'b1; #10;
      clock = 1'b0; #10;
   end

   // hard stop
   initial begin
      #40ms;
      $display("TEST FAILED");
      $finish;
   end

   // Result side: random stall per word, plus one long hold-off on request.
   initial begin
      int gap;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (400) @(negedge clock);
            hold_rsp = 1'b0;
         end
         gap = quiet ? 0 : $urandom_range(0, 14);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
         @(negedge clock);
      end
   end

   // one request word, random gap ahead of it
   task automatic send_word(func_type f, logic [2:0] dim, logic [23:0] c1, logic [23:0] c2);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tuser  <= f;
      req_tdata  <= {5'b0, c2, c1, dim};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      sent++;
      @(negedge clock);
   endtask

   // config writes only once the block has drained
   task automatic write_reg(logic [2:0] idx, logic [23:0] val);
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      csr_index <= idx;
      csr_wdata <= val;
      csr_we    <= 1'b1;
      @(negedge clock);
      csr_we    <= 1'b0;
      @(negedge clock);
   endtask

   // coordinate pair with a small difference most of the time, so the kernel stays nonzero
   task automatic send_pair(logic [2:0] dim);
      logic [23:0] c1, delta;
      c1 = $urandom;
      case ($urandom_range(0, 5))
         0:       delta = $urandom;
         1:       delta = $urandom_range(0, 24'h7ff) - 24'h400;
         default: delta = $urandom_range(0, 24'h3ffff) - 24'h20000;
      endcase
      send_word(FN_PAIR, dim, c1, c1 + delta);
   endtask

   // well-formed block: pairs, two lists, compute; now and then an out-of-range word
   task automatic run_block();
      int n1, n2, np;
      np = $urandom_range(0, 6);
      n1 = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8) : $urandom_range(0, 3);
      n2 = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8) : $urandom_range(0, 3);
      for (int k = 0; k < np; k++)
         send_pair($urandom_range(0, 5));
      for (int k = 0; k < n1; k++)
         send_word(FN_LIST1, $urandom_range(0, 5), $urandom, $urandom);
      for (int k = 0; k < n2; k++)
         send_word(FN_LIST2, $urandom_range(0, 5), $urandom, $urandom);
      if ($urandom_range(0, 4) == 0)
         send_word(func_type'($urandom_range(0, 2)), $urandom_range(6, 7), $urandom, $urandom);
      send_word(FN_COMPUTE, $urandom_range(0, 7), $urandom, $urandom);
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = FN_PAIR;
      csr_we     = 1'b0;
      csr_index  = REG_ALPHA;
      csr_wdata  = '0;
      quiet      = 1'b0;
      hold_rsp   = 1'b0;
      sent       = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed, reset config: empty-list compute, extremes, out-of-range dims, full lists
      send_word(FN_COMPUTE, 3'd0, 24'd0, 24'd0);
      send_word(FN_PAIR, 3'd0, 24'h7fffff, 24'h800000);
      send_word(FN_LIST1, 3'd0, 24'd0, 24'd0);
      send_word(FN_LIST2, 3'd0, 24'd0, 24'd0);
      send_word(FN_COMPUTE, 3'd0, 24'd0, 24'd0);
      send_word(FN_PAIR, 3'd0, 24'h000100, 24'hffff00);
      send_word(FN_PAIR, 3'd6, 24'h123456, 24'h654321);
      send_word(FN_PAIR, 3'd7, 24'hffffff, 24'h000000);
      for (int k = 0; k < 8; k++) send_word(FN_LIST1, k[2:0] % 3'd6, 24'd0, 24'd0);
      for (int k = 0; k < 8; k++) send_word(FN_LIST2, 3'd5 - k[2:0] % 3'd6, 24'd0, 24'd0);
      send_word(FN_LIST1, 3'd6, 24'd0, 24'd0);
      send_word(FN_LIST2, 3'd7, 24'd0, 24'd0);
      send_word(FN_COMPUTE, 3'd0, 24'd0, 24'd0);

      // phase 1: max gain, all dims, long receiver hold-off while computes queue up
      write_reg(REG_ALPHA, 24'hffffff);
      write_reg(REG_DIMS, 3'd6);
      for (int k = 0; k < 6; k++)
         write_reg(REG_LEN0 + k[2:0], $urandom_range(1, 24'h3ffff));
      for (int k = 0; k < 6; k++) send_pair(k[2:0]);
      for (int k = 0; k < 7; k++) send_word(FN_LIST1, k[2:0] % 3'd6, 24'd0, 24'd0);
      for (int k = 0; k < 7; k++) send_word(FN_LIST2, k[2:0] % 3'd6, 24'd0, 24'd0);
      hold_rsp = 1'b1;
      send_word(FN_COMPUTE, 3'd0, 24'd0, 24'd0);
      for (int k = 0; k < 3; k++) begin
         send_word(FN_LIST1, $urandom_range(0, 5), 24'd0, 24'd0);
         send_word(FN_COMPUTE, 3'd0, 24'd0, 24'd0);
      end
      while (sent < 70) run_block();

      // phase 2: smallest gain, no dimensions in the norm, extreme lengths, no idling in the first part
      write_reg(REG_ALPHA, 24'd1);
      write_reg(REG_DIMS, 3'd0);
      write_reg(REG_LEN0, 24'd1);
      write_reg(REG_LEN0 + 3'd1, 24'hffffff);
      quiet = 1'b1;
      while (sent < 95) run_block();
      // sender waits for the block to drain
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      quiet = 1'b0;
      while (sent < 120) run_block();

      // phase 3: dims above the limit, random gain
      write_reg(REG_ALPHA, $urandom_range(1, 24'hffffff));
      write_reg(REG_DIMS, 3'd7);
      for (int k = 0; k < 6; k++)
         write_reg(REG_LEN0 + k[2:0], $urandom_range(1, 24'h1ffff));
      while (sent < 160) run_block();

      // phase 4: single dimension, unit gain
      write_reg(REG_ALPHA, 24'd65536);
      write_reg(REG_DIMS, 3'd1);
      while (sent < 200) run_block();

      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (200) @(negedge clock);
      if (errors == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// ----- sim.f -----
hdl/sek_pkg.sv
hdl/sek_mul.sv
hdl/sek_dp.sv
hdl/sek_ctrl.sv
hdl/se_kernel_with_derivative_blocks.sv
hdl/sek_chk.sv
sim/se_kernel_checker.sv
sim/tb.sv
